>>> rtl/uvs_pkg.sv
// uvs_pkg: shared types, codes and byte classification for the UTF-8 stream validator.
// No dependencies; imported by every rtl module of the block.
`default_nettype none

package uvs_pkg;

	// Parser state, named for the role of the last accepted byte.
	typedef enum logic [3:0] {
		ST_ASC   = 4'd0,
		ST_LB2   = 4'd1,
		ST_LB3   = 4'd2,
		ST_LB3E0 = 4'd3,
		ST_LB3ED = 4'd4,
		ST_LB4   = 4'd5,
		ST_LB4F0 = 4'd6,
		ST_LB4F4 = 4'd7,
		ST_CB3   = 4'd8,
		ST_CB3F0 = 4'd9,
		ST_CB3F4 = 4'd10,
		ST_CB2   = 4'd11,
		ST_CB2E0 = 4'd12,
		ST_CB2ED = 4'd13,
		ST_CB1   = 4'd14,
		ST_INI   = 4'd15
	} uvs_state_t;

	typedef enum logic [1:0] {
		STAT_MID      = 2'd0,
		STAT_COMPLETE = 2'd1,
		STAT_REJECT   = 2'd2
	} uvs_status_t;

	// State-independent classification of one byte, done by the front.
	typedef struct packed {
		logic [7:0] data;     // raw byte
		logic       lead_ok;  // legal at a code point boundary
		uvs_state_t lead_st;  // state reached when taken as a boundary byte
		logic       r_std;    // 80-BF
		logic       r_e0;     // A0-BF
		logic       r_ed;     // 80-9F
		logic       r_f0;     // 90-BF
		logic       r_f4;     // 80-8F
	} uvs_item_t;

	// One result transfer.
	typedef struct packed {
		uvs_status_t status;
		logic [2:0]  seq_length;
		logic [31:0] seq_bytes;
	} uvs_result_t;

	// Bytes still to come, counting the byte that led into the state.
	function automatic logic [2:0] remaining(input uvs_state_t st);
		logic [2:0] r;
		unique case (st)
			ST_ASC, ST_CB1:                    r = 3'd1;
			ST_LB2, ST_CB2, ST_CB2E0, ST_CB2ED: r = 3'd2;
			ST_LB3, ST_LB3E0, ST_LB3ED,
			ST_CB3, ST_CB3F0, ST_CB3F4:        r = 3'd3;
			ST_LB4, ST_LB4F0, ST_LB4F4:        r = 3'd4;
			ST_INI:                            r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/uvs_front.sv
// uvs_front: classifies each incoming byte against the boundary and continuation ranges.
// Depends on uvs_pkg.
`default_nettype none

module uvs_front
	import uvs_pkg::*;
(
	input  wire logic [7:0] data_byte,
	output uvs_item_t       item
);

	always_comb begin
		item.data    = data_byte;
		item.lead_ok = 1'b1;
		item.lead_st = ST_ASC;
		priority if (data_byte < 8'h80) begin
			item.lead_st = ST_ASC;
		end else if (data_byte < 8'hC2) begin
			item.lead_ok = 1'b0;
		end else if (data_byte < 8'hE0) begin
			item.lead_st = ST_LB2;
		end else if (data_byte == 8'hE0) begin
			item.lead_st = ST_LB3E0;
		end else if (data_byte == 8'hED) begin
			item.lead_st = ST_LB3ED;
		end else if (data_byte < 8'hF0) begin
			item.lead_st = ST_LB3;
		end else if (data_byte == 8'hF0) begin
			item.lead_st = ST_LB4F0;
		end else if (data_byte == 8'hF4) begin
			item.lead_st = ST_LB4F4;
		end else if (data_byte < 8'hF4) begin
			item.lead_st = ST_LB4;
		end else begin
			item.lead_ok = 1'b0;
		end

		item.r_std = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
		item.r_e0  = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
		item.r_ed  = (data_byte >= 8'h80) && (data_byte <= 8'h9F);
		item.r_f0  = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
		item.r_f4  = (data_byte >= 8'h80) && (data_byte <= 8'h8F);
	end

endmodule

`default_nettype wire

>>> rtl/uvs_queue.sv
// uvs_queue: two-entry queue of classified bytes between front and back.
// Depends on uvs_pkg.
`default_nettype none

module uvs_queue
	import uvs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire uvs_item_t push_item,
	output logic           full,
	output logic           valid,
	input  wire logic      pop,
	output uvs_item_t      pop_item
);

	uvs_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

>>> rtl/uvs_back.sv
// uvs_back: parser state, sequence cache and registered result stage.
// Depends on uvs_pkg.
`default_nettype none

module uvs_back
	import uvs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire uvs_item_t in_item,
	output logic           in_take,
	output logic           out_valid,
	input  wire logic      out_take,
	output uvs_result_t    result
);

	uvs_state_t  state_q;
	logic [2:0]  exp_len_q;
	logic [7:0]  cache_q [4];
	logic        out_valid_q;
	uvs_result_t result_q;

	logic        step;
	logic        nxt_ok;
	uvs_state_t  nxt_st;
	logic        is_lead;
	logic [2:0]  len_new;
	logic [1:0]  pos;
	logic [7:0]  cache_new [4];

	assign step      = in_valid && (!out_valid_q || out_take);
	assign in_take   = step;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		nxt_ok = 1'b0;
		nxt_st = ST_INI;
		unique case (state_q)
			ST_INI, ST_ASC, ST_CB1: begin
				nxt_ok = in_item.lead_ok;
				nxt_st = in_item.lead_st;
			end
			ST_LB2:   begin nxt_ok = in_item.r_std; nxt_st = ST_CB1;   end
			ST_LB3:   begin nxt_ok = in_item.r_std; nxt_st = ST_CB2;   end
			ST_LB3E0: begin nxt_ok = in_item.r_e0;  nxt_st = ST_CB2E0; end
			ST_LB3ED: begin nxt_ok = in_item.r_ed;  nxt_st = ST_CB2ED; end
			ST_LB4:   begin nxt_ok = in_item.r_std; nxt_st = ST_CB3;   end
			ST_LB4F0: begin nxt_ok = in_item.r_f0;  nxt_st = ST_CB3F0; end
			ST_LB4F4: begin nxt_ok = in_item.r_f4;  nxt_st = ST_CB3F4; end
			ST_CB3, ST_CB3F0, ST_CB3F4: begin
				nxt_ok = in_item.r_std;
				nxt_st = ST_CB2;
			end
			ST_CB2, ST_CB2E0, ST_CB2ED: begin
				nxt_ok = in_item.r_std;
				nxt_st = ST_CB1;
			end
		endcase
	end

	// Boundary bytes reload the length and clear the cache before the write.
	always_comb begin
		is_lead = (nxt_st < ST_CB3);
		len_new = is_lead ? remaining(nxt_st) : exp_len_q;
		pos     = 2'(len_new - remaining(nxt_st));
		for (int i = 0; i < 4; i++) begin
			cache_new[i] = is_lead ? 8'h00 : cache_q[i];
		end
		cache_new[pos] = in_item.data;
		if (!nxt_ok) begin
			len_new = exp_len_q;
			for (int i = 0; i < 4; i++) begin
				cache_new[i] = cache_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INI;
			exp_len_q   <= 3'd0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				cache_q[i] <= 8'h00;
			end
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
				if (nxt_ok) begin
					state_q   <= nxt_st;
					exp_len_q <= len_new;
					for (int i = 0; i < 4; i++) begin
						cache_q[i] <= cache_new[i];
					end
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (!nxt_ok)
				result_q.status <= STAT_REJECT;
			else if (nxt_st == ST_ASC || nxt_st == ST_CB1)
				result_q.status <= STAT_COMPLETE;
			else
				result_q.status <= STAT_MID;
			result_q.seq_length <= len_new;
			result_q.seq_bytes  <= {cache_new[3], cache_new[2], cache_new[1], cache_new[0]};
		end
	end

endmodule

`default_nettype wire

>>> rtl/utf8_stream_validator.sv
// utf8_stream_validator: byte-serial well-formed UTF-8 checker, one result per byte.
// A pushed byte is written into the queue, then loaded into the back end's result register.
// Throughput: one byte per cycle while no unpopped result holds the back end.
// Reset (arst_n low, asynchronous): parser to the initial state, length 0, cache all
// zero, both queues empty. Depends on uvs_pkg, uvs_front, uvs_queue, uvs_back.
`default_nettype none

// Structure:
//   uvs_front  - classifies the pushed byte (boundary class and the five
//                continuation ranges) without looking at parser state.
//   uvs_queue  - two-entry queue of classified bytes; its full flag is the
//                push-side full, so the queue keeps taking bytes, up to its two
//                entries, while the back waits on a pop.
//   uvs_back   - owns parser state and the four-byte cache, resolves the
//                transfer against the current state and loads the result
//                register. It advances whenever a byte is queued and its result
//                register is free or being popped in the same cycle.
// A rejected byte still yields a result (status reject) reporting the
// unchanged length and cache.

module utf8_stream_validator
	import uvs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       status,
	output logic [2:0]       seq_length,
	output logic [31:0]      seq_bytes
);

	uvs_item_t   front_item;
	uvs_item_t   q_item;
	logic        q_valid;
	logic        q_take;
	logic        res_valid;
	uvs_result_t res;

	uvs_front u_front (
		.data_byte (data_byte),
		.item      (front_item)
	);

	uvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (full),
		.valid     (q_valid),
		.pop       (q_take),
		.pop_item  (q_item)
	);

	uvs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_item   (q_item),
		.in_take   (q_take),
		.out_valid (res_valid),
		.out_take  (pop),
		.result    (res)
	);

	// Result side looks like a queue: empty is the inverse of the result valid.
	assign empty      = !res_valid;
	assign status     = res.status;
	assign seq_length = res.seq_length;
	assign seq_bytes  = res.seq_bytes;

endmodule

`default_nettype wire
